FILE: hw/rtl/pkea_pkg.sv
package pkea_pkg;

  localparam int KeyW    = 31;
  localparam int OutEW   = 40;
  localparam int DepW    = 32;
  localparam int CntW    = 5;
  localparam int MaxRes  = 16;

  typedef enum logic [0:0] {
    OP_DEPOSIT = 1'b0,
    OP_REPORT  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DEP,
    BK_SCAN,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic               op;
    logic [KeyW-1:0]    track_key;
    logic signed [DepW-1:0] deposit_energy;
    logic [OutEW-1:0]   start_energy;
    logic               start_energy_given;
    logic [CntW-1:0]    report_count;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic [OutEW-1:0]   cell_total;
    logic [CntW-1:0]    entry_count;
    logic signed [31:0] best_key;
    logic [OutEW-1:0]   best_energy;
    logic [KeyW-1:0]    ranked_key;
    logic [OutEW-1:0]   ranked_energy;
    logic [OutEW-1:0]   ranked_start_energy;
    logic               ranked_start_known;
    logic               entry_valid;
    logic               last;
  } out_item_t;

  // Classified command from the front end.
  typedef struct packed {
    logic            is_report;
    logic            ignore;
    logic [KeyW-1:0] key;
    logic [DepW-2:0] amount;
    logic [OutEW-1:0] start_energy;
    logic            start_given;
    logic [CntW-1:0] want;
  } cmd_t;

endpackage

FILE: hw/rtl/pkea_if.sv
interface pkea_in_if;
  logic valid;
  logic ready;
  pkea_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pkea_out_if;
  logic valid;
  logic ready;
  pkea_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/pkea_front.sv
module pkea_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  pkea_in_if.sink           in_if,
  output logic              cmd_valid_o,
  output pkea_pkg::cmd_t    cmd_o,
  input  logic              cmd_ready_i
);
  import pkea_pkg::*;

  // Two-entry queue of classified commands.
  cmd_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       c;
  logic       push, pop;

  always_comb begin
    c = '0;
    c.is_report    = (in_if.payload.op == OP_REPORT);
    c.ignore       = (in_if.payload.deposit_energy <= 0);
    c.key          = in_if.payload.track_key;
    c.amount       = in_if.payload.deposit_energy[DepW-2:0];
    c.start_energy = in_if.payload.start_energy;
    c.start_given  = in_if.payload.start_energy_given;
    c.want         = in_if.payload.report_count;
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: hw/rtl/pkea_back.sv
module pkea_back #(
  parameter int TRACK_SLOTS = 16,
  parameter int ENERGY_BITS = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  pkea_pkg::cmd_t    cmd_i,
  output logic              cmd_ready_o,
  pkea_out_if.source        out_if
);
  import pkea_pkg::*;

  localparam int IdxW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int UcW  = $clog2(TRACK_SLOTS + 1);
  localparam logic [ENERGY_BITS-1:0] EMax = '1;

  logic [KeyW-1:0]        key_q   [TRACK_SLOTS];
  logic [ENERGY_BITS-1:0] en_q    [TRACK_SLOTS];
  logic [ENERGY_BITS-1:0] se_q    [TRACK_SLOTS];
  logic [TRACK_SLOTS-1:0] known_q, used_q, taken_q;
  logic [ENERGY_BITS-1:0] total_q;
  logic [UcW-1:0]         ucnt_q;

  bk_state_e              state_q, state_d;
  cmd_t                   cmd_q;
  logic [IdxW-1:0]        scan_q;
  logic                   bfound_q;
  logic [IdxW-1:0]        bidx_q;
  logic [CntW-1:0]        left_q;

  out_item_t              o_q;
  logic                   ov_q;

  // Parallel key match and first free slot.
  logic                   hit, freef;
  logic [IdxW-1:0]        hit_idx, free_idx;
  always_comb begin
    hit = 1'b0; freef = 1'b0; hit_idx = '0; free_idx = '0;
    for (int i = 0; i < TRACK_SLOTS; i++) begin
      if (used_q[i]) begin
        if (!hit && key_q[i] == cmd_q.key) begin
          hit = 1'b1; hit_idx = IdxW'(i);
        end
      end else if (!freef) begin
        freef = 1'b1; free_idx = IdxW'(i);
      end
    end
  end

  // Running best of all used slots; also the summary fields.
  logic                   sbest_v;
  logic [IdxW-1:0]        sbest;
  logic                   out_free;
  assign out_free = !ov_q || out_if.ready;

  function automatic logic [ENERGY_BITS-1:0] sat(input logic [ENERGY_BITS-1:0] a,
                                                 input logic [ENERGY_BITS-1:0] b);
    logic [ENERGY_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ENERGY_BITS] ? EMax : s[ENERGY_BITS-1:0];
  endfunction

  // Clamp the deposit to the accumulator range before adding.
  logic [ENERGY_BITS-1:0] amt;
  assign amt = (64'(cmd_q.amount) > 64'(EMax)) ? EMax : ENERGY_BITS'(cmd_q.amount);

  // Summary is maintained as registered best of all used slots.
  logic                   best_v_q;
  logic [IdxW-1:0]        best_q;

  always_comb begin
    sbest_v = best_v_q;
    sbest   = best_q;
  end

  function automatic logic [OutEW-1:0] tr(input logic [ENERGY_BITS-1:0] v);
    logic [OutEW+ENERGY_BITS-1:0] w;
    w = (OutEW+ENERGY_BITS)'(v);
    return w[OutEW-1:0];
  endfunction

  logic [CntW-1:0] ucnt_out;
  assign ucnt_out = (ucnt_q > UcW'(31)) ? CntW'(31) : CntW'(ucnt_q);

  logic [CntW-1:0] want_c;
  always_comb begin
    want_c = cmd_i.want;
    if (UcW'(want_c) > ucnt_q && 32'(want_c) <= 32'(TRACK_SLOTS)) want_c = CntW'(ucnt_q);
    else if (32'(want_c) > 32'(ucnt_q)) want_c = CntW'(ucnt_q);
    if (want_c > CntW'(MaxRes)) want_c = CntW'(MaxRes);
  end

  // Deposit result and the summary after the update. Energies only grow, so
  // the new best is either the old best or the entry just updated.
  logic                   dep_apply, upd_wins, nb_v;
  logic [IdxW-1:0]        upd_idx, nb;
  logic [ENERGY_BITS-1:0] upd_en;
  out_item_t              dep_o;
  always_comb begin
    dep_apply = !cmd_q.is_report && !cmd_q.ignore && (hit || freef);
    upd_idx   = hit ? hit_idx : free_idx;
    upd_en    = hit ? sat(en_q[hit_idx], amt) : amt;
    upd_wins  = !best_v_q || (upd_en > en_q[best_q]) ||
                (upd_en == en_q[best_q] && cmd_q.key < key_q[best_q]);
    nb_v      = best_v_q || dep_apply;
    nb        = (dep_apply && upd_wins) ? upd_idx : best_q;
    dep_o             = '0;
    dep_o.kind        = cmd_q.is_report;
    dep_o.status      = ST_OK;
    dep_o.cell_total  = tr(total_q);
    dep_o.entry_count = ucnt_out;
    dep_o.best_key    = best_v_q ? {1'b0, key_q[best_q]} : '1;
    dep_o.best_energy = best_v_q ? tr(en_q[best_q]) : '0;
    dep_o.last        = 1'b1;
    if (!cmd_q.is_report) begin
      if (cmd_q.ignore) dep_o.status = ST_IGNORED;
      else begin
        dep_o.cell_total = tr(sat(total_q, amt));
        if (!hit && !freef) dep_o.status = ST_FULL;
        else if (!hit) begin
          dep_o.entry_count = (ucnt_q + UcW'(1) > UcW'(31)) ? CntW'(31) :
                              CntW'(ucnt_q + UcW'(1));
        end
      end
    end
    if (dep_apply && upd_wins) begin
      dep_o.best_key    = {1'b0, cmd_q.key};
      dep_o.best_energy = tr(upd_en);
    end
  end

  // Scan comparison: candidate scan_q versus current best.
  logic cand_better;
  always_comb begin
    cand_better = 1'b0;
    if (used_q[scan_q] && !taken_q[scan_q]) begin
      if (!bfound_q) cand_better = 1'b1;
      else if (en_q[scan_q] != en_q[bidx_q]) cand_better = en_q[scan_q] > en_q[bidx_q];
      else cand_better = key_q[scan_q] < key_q[bidx_q];
    end
  end

  assign cmd_ready_o = (state_q == BK_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (cmd_valid_i && cmd_ready_o) begin
        if (cmd_i.is_report && want_c != '0) state_d = BK_SCAN;
        else state_d = BK_DEP;
      end
      BK_DEP:  if (out_free) state_d = BK_IDLE;
      BK_SCAN: if (32'(scan_q) == TRACK_SLOTS - 1) state_d = BK_EMIT;
      BK_EMIT: if (out_free) state_d = (left_q == CntW'(1)) ? BK_IDLE : BK_SCAN;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    if (state_q == BK_DEP && out_free && !cmd_q.is_report && !cmd_q.ignore) begin
      if (hit || freef) begin
        if (!hit) begin
          key_q[free_idx] <= cmd_q.key;
          en_q[free_idx]  <= sat('0, amt);
          if (cmd_q.start_given)
            se_q[free_idx] <= (ENERGY_BITS >= OutEW || cmd_q.start_energy <= OutEW'(EMax)) ?
                              ENERGY_BITS'(cmd_q.start_energy) : EMax;
        end else begin
          en_q[hit_idx] <= sat(en_q[hit_idx], amt);
          if (cmd_q.start_given && !known_q[hit_idx])
            se_q[hit_idx] <= (ENERGY_BITS >= OutEW || cmd_q.start_energy <= OutEW'(EMax)) ?
                             ENERGY_BITS'(cmd_q.start_energy) : EMax;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      used_q      <= '0;
      known_q     <= '0;
      taken_q     <= '0;
      total_q     <= '0;
      ucnt_q      <= '0;
      scan_q      <= '0;
      bfound_q    <= 1'b0;
      bidx_q      <= '0;
      left_q      <= '0;
      ov_q        <= 1'b0;
      o_q         <= '0;
      best_v_q    <= 1'b0;
      best_q      <= '0;
    end else begin
      state_q <= state_d;
      // Load a result or hold the pending one until it is taken.
      ov_q <= ((state_q == BK_DEP || state_q == BK_EMIT) && out_free) ||
              (ov_q && !out_if.ready);

      unique case (state_q)
        BK_IDLE: if (cmd_valid_i && cmd_ready_o) begin
          left_q   <= want_c;
          scan_q   <= '0;
          bfound_q <= 1'b0;
          taken_q  <= '0;
        end
        BK_DEP: if (out_free) begin
          o_q      <= dep_o;
          best_v_q <= nb_v;
          best_q   <= nb;
          if (!cmd_q.is_report && !cmd_q.ignore) begin
            total_q <= sat(total_q, amt);
            if (dep_apply && !hit) begin
              used_q[free_idx]  <= 1'b1;
              known_q[free_idx] <= cmd_q.start_given;
              ucnt_q            <= ucnt_q + UcW'(1);
            end else if (dep_apply && cmd_q.start_given) begin
              known_q[hit_idx] <= 1'b1;
            end
          end
        end
        BK_SCAN: begin
          if (cand_better) begin
            bfound_q <= 1'b1; bidx_q <= scan_q;
          end
          if (32'(scan_q) != TRACK_SLOTS - 1) scan_q <= scan_q + IdxW'(1);
        end
        BK_EMIT: if (out_free) begin
          o_q.kind                <= 1'b1;
          o_q.status              <= ST_OK;
          o_q.cell_total          <= tr(total_q);
          o_q.entry_count         <= ucnt_out;
          o_q.best_key            <= sbest_v ? {1'b0, key_q[sbest]} : '1;
          o_q.best_energy         <= sbest_v ? tr(en_q[sbest]) : '0;
          o_q.ranked_key          <= key_q[bidx_q];
          o_q.ranked_energy       <= tr(en_q[bidx_q]);
          o_q.ranked_start_energy <= known_q[bidx_q] ? tr(se_q[bidx_q]) : '0;
          o_q.ranked_start_known  <= known_q[bidx_q];
          o_q.entry_valid         <= 1'b1;
          o_q.last                <= (left_q == CntW'(1));
          taken_q[bidx_q]         <= 1'b1;
          left_q                  <= left_q - CntW'(1);
          scan_q                  <= '0;
          bfound_q                <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_if.valid   = ov_q;
  assign out_if.payload = o_q;
endmodule

FILE: hw/rtl/per_key_energy_accumulator_topn.sv
// Keyed energy accumulator: a deposit is first taken from the queue, then its
// key is matched against all TRACK_SLOTS entries in parallel, the entry and the
// largest-contributor summary are updated, and the result register is loaded.
// A report of n entries is taken from the queue and then makes n passes, each
// comparing one slot at a time with the single ranking comparator and then
// emitting the entry. A stalled output holds the back end; a two-item
// queue in front lets input continue while the back end works.
module per_key_energy_accumulator_topn #(
  parameter int TRACK_SLOTS = 16,
  parameter int ENERGY_BITS = 40
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pkea_in_if.sink    in_if,
  pkea_out_if.source out_if
);
  import pkea_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  pkea_front u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  pkea_back #(.TRACK_SLOTS(TRACK_SLOTS), .ENERGY_BITS(ENERGY_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_if
  );

  a_empty_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.payload.entry_count == '0) |->
      (out_if.payload.best_key == -32'sd1)) else $error("best key set on empty table");
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.payload.kind == 1'b0) |-> out_if.payload.last)
    else $error("deposit ack without last");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> $stable(out_if.payload))
    else $error("result changed while stalled");
endmodule

FILE: test/tb_per_key_energy_accumulator_topn.sv
module tb_per_key_energy_accumulator_topn;
  import pkea_pkg::*;

  localparam int Slots      = 16;
  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 400;
  localparam logic [39:0] EMax = 40'hFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pkea_in_if  in_if ();
  pkea_out_if out_if ();

  per_key_energy_accumulator_topn dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #6 clk_i = ~clk_i;

  // Table mirror
  logic [30:0] tk_key    [Slots];
  logic [39:0] tk_energy [Slots];
  logic [39:0] tk_start  [Slots];
  logic        tk_known  [Slots];
  logic        tk_used   [Slots];
  logic [39:0] cell_sum;
  int          held;

  out_item_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int burst_left = 0;
  event hold_ev;

  function automatic logic [39:0] sat_sum(logic [39:0] a, logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? EMax : s[39:0];
  endfunction

  function automatic bit outranks(int i, int j);
    if (tk_energy[i] != tk_energy[j]) return tk_energy[i] > tk_energy[j];
    return tk_key[i] < tk_key[j];
  endfunction

  function automatic int top_slot(bit taken[Slots]);
    int b;
    b = -1;
    for (int i = 0; i < Slots; i++) begin
      if (!tk_used[i] || taken[i]) continue;
      if (b < 0 || outranks(i, b)) b = i;
    end
    return b;
  endfunction

  function automatic out_item_t summary(logic kind, status_e st);
    out_item_t o;
    bit none[Slots];
    int b;
    for (int i = 0; i < Slots; i++) none[i] = 1'b0;
    b = top_slot(none);
    o = '0;
    o.kind = kind;
    o.status = st;
    o.cell_total = cell_sum;
    o.entry_count = held[4:0];
    o.best_key = (b < 0) ? -32'sd1 : {1'b0, tk_key[b]};
    o.best_energy = (b < 0) ? '0 : tk_energy[b];
    o.last = 1'b1;
    return o;
  endfunction

  task automatic predict_item(in_item_t it);
    out_item_t o;
    bit taken[Slots];
    int hit, freei, want, b;
    logic [39:0] amt;
    status_e st;
    if (it.op == OP_DEPOSIT) begin
      if (it.deposit_energy <= 0) begin
        expected_q.push_back(summary(OP_DEPOSIT, ST_IGNORED));
        return;
      end
      amt = {8'd0, it.deposit_energy};
      cell_sum = sat_sum(cell_sum, amt);
      hit = -1;
      freei = -1;
      for (int i = 0; i < Slots; i++) begin
        if (tk_used[i]) begin
          if (hit < 0 && tk_key[i] == it.track_key) hit = i;
        end else if (freei < 0) begin
          freei = i;
        end
      end
      if (hit < 0 && freei >= 0) begin
        hit = freei;
        tk_used[hit] = 1'b1;
        tk_key[hit] = it.track_key;
        tk_energy[hit] = '0;
        tk_known[hit] = 1'b0;
        tk_start[hit] = '0;
        held++;
      end
      st = ST_OK;
      if (hit < 0) begin
        st = ST_FULL;
      end else begin
        tk_energy[hit] = sat_sum(tk_energy[hit], amt);
        if (it.start_energy_given && !tk_known[hit]) begin
          tk_known[hit] = 1'b1;
          tk_start[hit] = it.start_energy;
        end
      end
      expected_q.push_back(summary(OP_DEPOSIT, st));
    end else begin
      want = it.report_count;
      if (want > held) want = held;
      if (want > MaxRes) want = MaxRes;
      if (want == 0) begin
        expected_q.push_back(summary(OP_REPORT, ST_OK));
        return;
      end
      for (int i = 0; i < Slots; i++) taken[i] = 1'b0;
      for (int k = 0; k < want; k++) begin
        o = summary(OP_REPORT, ST_OK);
        o.last = (k + 1 == want);
        b = top_slot(taken);
        if (b >= 0) begin
          taken[b] = 1'b1;
          o.ranked_key = tk_key[b];
          o.ranked_energy = tk_energy[b];
          o.ranked_start_energy = tk_known[b] ? tk_start[b] : '0;
          o.ranked_start_known = tk_known[b];
          o.entry_valid = 1'b1;
        end
        expected_q.push_back(o);
      end
    end
  endtask

  // Send one item; bursts of random length, often separated by random gaps.
  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic in_item_t deposit(logic [30:0] key, logic signed [31:0] e,
                                       logic [39:0] se, logic given);
    in_item_t it;
    it = '0;
    it.op = OP_DEPOSIT;
    it.track_key = key;
    it.deposit_energy = e;
    it.start_energy = se;
    it.start_energy_given = given;
    it.report_count = 5'($urandom);
    return it;
  endfunction

  function automatic in_item_t report(logic [4:0] n);
    in_item_t it;
    it = '0;
    it.op = OP_REPORT;
    it.track_key = 31'($urandom);
    it.deposit_energy = 32'($urandom);
    it.start_energy = {8'($urandom), 32'($urandom)};
    it.start_energy_given = 1'($urandom);
    it.report_count = n;
    return it;
  endfunction

  function automatic in_item_t rand_deposit(int key_span);
    logic signed [31:0] e;
    case ($urandom_range(0, 9))
      0:       e = -$signed({1'b0, 31'($urandom)});
      1:       e = 32'sd0;
      2:       e = 32'sh7FFF_FFFF - 32'($urandom_range(0, 3));
      default: e = $signed({1'b0, 31'($urandom_range(1, 32'h00FF_FFFF))});
    endcase
    return deposit(31'($urandom_range(0, key_span)) ^ (($urandom_range(0, 7) == 0) ?
                   31'h7FFF_FFF0 : 31'd0), e, {8'($urandom), 32'($urandom)},
                   1'($urandom));
  endfunction

  // Results checker
  always @(posedge clk_i) begin
    out_item_t got, exp_o;
    if (out_if.valid && out_if.ready) begin
      got = out_if.payload;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_o = expected_q.pop_front();
        if (got.kind !== exp_o.kind || got.status !== exp_o.status ||
            got.cell_total !== exp_o.cell_total ||
            got.entry_count !== exp_o.entry_count ||
            got.best_key !== exp_o.best_key || got.best_energy !== exp_o.best_energy ||
            got.ranked_key !== exp_o.ranked_key ||
            got.ranked_energy !== exp_o.ranked_energy ||
            got.ranked_start_energy !== exp_o.ranked_start_energy ||
            got.ranked_start_known !== exp_o.ranked_start_known ||
            got.entry_valid !== exp_o.entry_valid || got.last !== exp_o.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_o, got);
          errors++;
        end
      end
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering items
  always begin
    @(hold_ev);
    hold_off = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // Receiver stall pattern, with an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else if (hold_off) out_if.ready <= 1'b0;
    else if (($time / 600) % 3 == 0) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(report(5'd16));
    send_item(deposit(31'd5, 32'sd0, 40'd7, 1'b1));
    send_item(deposit(31'd5, -32'sd1, 40'd7, 1'b1));
    send_item(deposit(31'd5, 32'sh8000_0000, 40'd7, 1'b1));
    send_item(deposit(31'd5, 32'sd100, 40'd0, 1'b0));
    send_item(deposit(31'd5, 32'sd50, EMax, 1'b1));
    send_item(deposit(31'd5, 32'sd1, 40'd9, 1'b1));
    send_item(deposit(31'h7FFF_FFFF, 32'sh7FFF_FFFF, EMax, 1'b1));
    send_item(deposit(31'd0, 32'sd150, 40'd3, 1'b1));
    send_item(deposit(31'd2, 32'sd151, 40'd0, 1'b0));
    send_item(report(5'd0));
    send_item(report(5'd1));
    send_item(report(5'd31));
    for (int i = 0; i < 14; i++) send_item(deposit(31'(100 + i), 32'sd151, 40'(i), 1'b1));
    send_item(deposit(31'd2, 32'sd10, 40'd1, 1'b1));
    send_item(report(5'd16));
  endtask

  task automatic test_large();
    for (int i = 0; i < 40; i++)
      send_item(deposit(31'h7FFF_FFFF, 32'sh7FFF_FFFF, 40'd0, 1'b0));
    send_item(report(5'd3));
  endtask

  task automatic test_random();
    for (int i = 0; i < 250; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(report(5'($urandom_range(0, 31))));
      else send_item(rand_deposit(40));
    end
  endtask

  task automatic test_backpressure();
    -> hold_ev;
    for (int i = 0; i < 6; i++) send_item(report(5'd16));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cell_sum = '0;
    held = 0;
    for (int i = 0; i < Slots; i++) begin
      tk_used[i] = 1'b0;
      tk_known[i] = 1'b0;
      tk_key[i] = '0;
      tk_energy[i] = '0;
      tk_start[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    test_large();
    drain();
    if (expected_q.size() != 0) errors++;
    $display("Sent %0d items, checked %0d results: deposits, ignores, full table,",
             items_sent, results_seen);
    $display("reports of every length, large deposits and a long output stall.");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pkea_pkg.sv
hw/rtl/pkea_if.sv
hw/rtl/pkea_front.sv
hw/rtl/pkea_back.sv
hw/rtl/per_key_energy_accumulator_topn.sv
test/tb_per_key_energy_accumulator_topn.sv
